/* src/tsd_pkg.sv */
`timescale 1ns / 1ps

package tsd_pkg;

    localparam int PERIOD_WIDTH = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int TEMP_W       = 12;

    localparam logic [32:0] COUNT_MAX = (33'd1 << PERIOD_WIDTH) - 33'd1;

    typedef enum logic [2:0] {
        MODE_STOP  = 3'd0,
        MODE_HEAT  = 3'd1,
        MODE_VLOW  = 3'd2,
        MODE_VMID  = 3'd3,
        MODE_VHIGH = 3'd4
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_PERIOD_SLOW = 3'd1,
        REG_PERIOD_MID  = 3'd2,
        REG_PERIOD_FAST = 3'd3,
        REG_LAMP_POL    = 3'd4
    } t_reg_index;

    typedef enum logic {
        OP_READING = 1'b0,
        OP_TICK    = 1'b1
    } t_op;

    typedef struct packed {
        logic                     operation;
        logic signed [TEMP_W-1:0] temperature;
    } t_in_req;

    typedef struct packed {
        logic [3:0] coils;
        logic [2:0] drive_mode;
        logic       lamp;
        logic       stepped;
    } t_out_rsp;

    function automatic logic [3:0] coil_phase(input logic [2:0] idx);
        logic [3:0] c;
        case (idx)
            3'd0:    c = 4'h1;
            3'd1:    c = 4'h5;
            3'd2:    c = 4'h4;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'h2;
            3'd5:    c = 4'hA;
            3'd6:    c = 4'h8;
            3'd7:    c = 4'h9;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

    // zero period steps every tick; saturate when the count is narrower
    function automatic logic [PERIOD_WIDTH-1:0] reload_value(input logic [15:0] period);
        logic [15:0] p;
        logic [32:0] w;
        logic [PERIOD_WIDTH-1:0] r;
        p = (period == 16'd0) ? 16'd0 : (period - 16'd1);
        w = {17'd0, p};
        if (w > COUNT_MAX) begin
            r = '1;
        end else begin
            r = w[PERIOD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

/* src/thermostat_stepper_driver_top.sv */
`timescale 1ns / 1ps

// Thermostat stepper driver.
// Input channel (i_in_valid / o_in_ready / i_in_req): each request is either a
// temperature reading, which picks one of five drive modes against the setpoint,
// or a one-microsecond tick, which paces an 8-phase half-step coil sequence.
// Output channel (o_out_valid / i_out_ready / o_out_rsp): exactly one response
// per request, in order: coil levels, drive mode, lamp level, stepped flag.
// o_out_valid rises in the cycle after acceptance. Throughput is one request
// per cycle while i_out_ready is high; the mode compare and the count/phase
// update sit between the state registers and the single response register.
// When the receiver stalls, the response register holds and o_in_ready stays
// high only while that register is empty or being drained in the same cycle.
// Configuration writes (i_cfg_wr_en, i_cfg_index, i_cfg_wr_data) take effect at
// once and are expected only while the block is idle.
// Reset: mode stop, phase 0, count 0, coils off, configuration at defaults,
// no response pending. No clearing pass is needed.
module thermostat_stepper_driver_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tsd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  tsd_pkg::t_in_req               i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output tsd_pkg::t_out_rsp              o_out_rsp
);
    import tsd_pkg::*;

    logic signed [TEMP_W-1:0] r_setpoint;
    logic [15:0]              r_period_slow;
    logic [15:0]              r_period_mid;
    logic [15:0]              r_period_fast;
    logic                     r_lamp_pol;

    t_mode                    r_mode, n_mode;
    logic [2:0]               r_phase, n_phase;
    logic [PERIOD_WIDTH-1:0]  r_count, n_count;
    logic [3:0]               r_coils, n_coils;
    logic                     n_stepped;

    logic                     r_out_valid;
    t_out_rsp                 r_out_rsp, n_out_rsp;

    logic                     accept;
    logic signed [TEMP_W+1:0] diff;
    t_mode                    pick;
    logic [15:0]              period_sel;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint    <= 12'sd250;
            r_period_slow <= 16'd10000;
            r_period_mid  <= 16'd3333;
            r_period_fast <= 16'd1667;
            r_lamp_pol    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SETPOINT:    r_setpoint    <= i_cfg_wr_data[TEMP_W-1:0];
                REG_PERIOD_SLOW: r_period_slow <= i_cfg_wr_data[15:0];
                REG_PERIOD_MID:  r_period_mid  <= i_cfg_wr_data[15:0];
                REG_PERIOD_FAST: r_period_fast <= i_cfg_wr_data[15:0];
                REG_LAMP_POL:    r_lamp_pol    <= i_cfg_wr_data[0];
                default:         ;
            endcase
        end
    end

    assign diff = {{2{i_in_req.temperature[TEMP_W-1]}}, i_in_req.temperature}
                - {{2{r_setpoint[TEMP_W-1]}}, r_setpoint};

    always_comb begin
        if (diff < -14'sd10) begin
            pick = MODE_HEAT;
        end else if (diff <= 14'sd10) begin
            pick = MODE_STOP;
        end else if (diff < 14'sd30) begin
            pick = MODE_VLOW;
        end else if (diff <= 14'sd50) begin
            pick = MODE_VMID;
        end else begin
            pick = MODE_VHIGH;
        end
    end

    always_comb begin
        case (r_mode)
            MODE_VMID:  period_sel = r_period_mid;
            MODE_VHIGH: period_sel = r_period_fast;
            default:    period_sel = r_period_slow;
        endcase
    end

    always_comb begin
        n_mode = r_mode;
        if (i_in_req.operation == OP_READING) begin
            n_mode = pick;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_coils   = r_coils;
        n_stepped = 1'b0;
        if (i_in_req.operation == OP_TICK) begin
            case (r_mode)
                MODE_HEAT, MODE_VLOW, MODE_VMID, MODE_VHIGH: begin
                    if (r_count == '0) begin
                        n_coils   = coil_phase(r_phase);
                        n_phase   = (r_mode == MODE_HEAT) ? r_phase + 3'd1 : r_phase - 3'd1;
                        n_count   = reload_value(period_sel);
                        n_stepped = 1'b1;
                    end else begin
                        n_count = r_count - PERIOD_WIDTH'(1);
                    end
                end
                default: begin
                    n_coils = 4'h0;
                    n_count = '0;
                end
            endcase
        end
    end

    always_comb begin
        n_out_rsp.coils      = n_coils;
        n_out_rsp.drive_mode = n_mode;
        n_out_rsp.lamp       = (n_mode == MODE_HEAT) ^ r_lamp_pol;
        n_out_rsp.stepped    = n_stepped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STOP;
            r_phase     <= 3'd0;
            r_count     <= '0;
            r_coils     <= 4'h0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_phase <= n_phase;
                r_count <= n_count;
                r_coils <= n_coils;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_rsp <= n_out_rsp;
        end
    end

endmodule

/* src/tsd_checker.sv */
`timescale 1ns / 1ps

module tsd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [tsd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  tsd_pkg::t_in_req                i_in_req,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  tsd_pkg::t_out_rsp               o_out_rsp
);
    import tsd_pkg::*;

    logic unused_cfg;
    assign unused_cfg = i_cfg_wr_en ^ (^i_cfg_index) ^ (^i_cfg_wr_data);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("response changed while stalled");

    a_step_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.stepped |-> o_out_rsp.drive_mode != MODE_STOP)
        else $error("step reported in stop mode");

    a_step_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.stepped |->
            ($countones(o_out_rsp.coils) == 1 || $countones(o_out_rsp.coils) == 2))
        else $error("step applied an invalid coil phase");

    a_reading_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_req.operation == OP_READING |=>
            o_out_valid && !o_out_rsp.stepped)
        else $error("reading did not produce a non-stepping response");

endmodule

bind thermostat_stepper_driver_top tsd_checker u_tsd_checker (.*);
